[sv/frws_pkg.sv]
// frws_pkg: widths, constants and controller/datapath handshake types
// for the frame rate window statistics block
// no dependencies; used by every other file of the block but frws_ram
package frws_pkg;

  // item field widths
  localparam int RATE_W  = 24;
  localparam int TICKS_W = 24;
  localparam int TPS_W   = 32;
  localparam int FRAC_W  = 8;

  // saturation value of every rate (unsigned Q16.8)
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // configuration register
  localparam logic [TPS_W-1:0] TPS_RESET = 32'd1000000;
  localparam int               APB_AW    = 3;
  localparam logic             REG_TPS   = 1'b0;

  // shared serial divider
  localparam int DIVIDEND_W = TPS_W + FRAC_W;
  localparam int DIVISOR_W  = TICKS_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic start_rate;
    logic push;
    logic start_stats;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic scan_busy;
    logic out_free;
  } status_t;

endpackage

[sv/frws_ram.sv]
// frws_ram: generic single-port RAM with registered read data
// no dependencies
module frws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port share the address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/frws_div.sv]
// frws_div: restoring divider, one quotient bit per cycle
// depends on frws_pkg
module frws_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [frws_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [frws_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                            busy_o,
  output logic [frws_pkg::DIVIDEND_W-1:0] quotient_o
);

  localparam int DW = frws_pkg::DIVIDEND_W;
  localparam int VW = frws_pkg::DIVISOR_W;
  localparam int CW = frws_pkg::DIV_CNT_W;

  logic [VW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;

  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          qbit;
  logic [VW-1:0] rem_d;

  // one trial subtraction per step
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    qbit    = (shifted >= {1'b0, dvs_q});
    rem_d   = qbit ? diff[VW-1:0] : shifted[VW-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DW-2:0], qbit};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[sv/frws_dp.sv]
// frws_dp: datapath with rate register, window store, running sum,
// min/max scan and output register; depends on frws_pkg, frws_div, frws_ram
module frws_dp #(
  parameter int WINDOW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  frws_pkg::cmd_t                cmd_i,
  output frws_pkg::status_t             status_o,
  input  logic [frws_pkg::TICKS_W-1:0]  frame_ticks_i,
  input  logic                          cfg_we_i,
  input  logic [frws_pkg::TPS_W-1:0]    cfg_wdata_i,
  output logic [frws_pkg::TPS_W-1:0]    tps_o,
  input  logic                          stats_ready_i,
  output logic                          stats_valid_o,
  output logic [frws_pkg::RATE_W-1:0]   current_rate_o,
  output logic [frws_pkg::RATE_W-1:0]   average_rate_o,
  output logic [frws_pkg::RATE_W-1:0]   minimum_rate_o,
  output logic [frws_pkg::RATE_W-1:0]   maximum_rate_o
);

  localparam int RW     = frws_pkg::RATE_W;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = RW + $clog2(WINDOW);

  logic [frws_pkg::TPS_W-1:0]      tps_q;
  logic                            ticks_zero_q;
  logic [RW-1:0]                   rate_q;
  logic [FILL_W-1:0]               fill_q;
  logic [SLOT_W-1:0]               slot_q;
  logic [SUM_W-1:0]                sum_q;
  logic                            scan_active_q;
  logic                            rd_valid_q;
  logic [FILL_W-1:0]               idx_q;
  logic [RW-1:0]                   lo_q;
  logic [RW-1:0]                   hi_q;
  logic                            out_valid_q;
  logic [RW-1:0]                   cur_out_q;
  logic [RW-1:0]                   avg_out_q;
  logic [RW-1:0]                   min_out_q;
  logic [RW-1:0]                   max_out_q;

  logic                              div_start;
  logic [frws_pkg::DIVIDEND_W-1:0]   div_dividend;
  logic [frws_pkg::DIVISOR_W-1:0]    div_divisor;
  logic                              div_busy;
  logic [frws_pkg::DIVIDEND_W-1:0]   div_quo;
  logic                              rate_sat;
  logic [RW-1:0]                     rate;
  logic                              full;
  logic [SLOT_W-1:0]                 ram_addr;
  logic                              ram_re;
  logic [RW-1:0]                     ram_rdata;
  logic [SUM_W-1:0]                  drop_val;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= frws_pkg::TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  assign tps_o = tps_q;

  // shared divider: rate first, then the window average
  assign div_start    = cmd_i.start_rate | cmd_i.start_stats;
  assign div_dividend = cmd_i.start_rate ? {tps_q, {frws_pkg::FRAC_W{1'b0}}}
                                         : frws_pkg::DIVIDEND_W'(sum_q);
  assign div_divisor  = cmd_i.start_rate ? frame_ticks_i
                                         : frws_pkg::DIVISOR_W'(fill_q);

  frws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // saturate the rate quotient
  assign rate_sat = ticks_zero_q | (|div_quo[frws_pkg::DIVIDEND_W-1:RW]);
  assign rate     = rate_sat ? frws_pkg::RATE_MAX : div_quo[RW-1:0];

  // window store: old entry read on accept, write on push, then scan
  assign full     = (fill_q == FILL_W'(WINDOW));
  assign ram_addr = cmd_i.push    ? slot_q :
                    scan_active_q ? idx_q[SLOT_W-1:0] : slot_q;
  assign ram_re   = cmd_i.load_item | scan_active_q;

  frws_ram #(
    .WIDTH (RW),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (rate),
    .rdata_o (ram_rdata)
  );

  assign drop_val = full ? SUM_W'(ram_rdata) : '0;

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      ticks_zero_q <= (frame_ticks_i == '0);
    end
    if (cmd_i.push) begin
      rate_q <= rate;
    end
  end

  // window bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.push) begin
      sum_q <= sum_q - drop_val + SUM_W'(rate);
      if (!full) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      if (slot_q == SLOT_W'(WINDOW - 1)) begin
        slot_q <= '0;
      end else begin
        slot_q <= slot_q + SLOT_W'(1);
      end
    end
  end

  // scan address sequencer over the filled entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_active_q <= 1'b0;
      rd_valid_q    <= 1'b0;
      idx_q         <= '0;
    end else begin
      rd_valid_q <= scan_active_q;
      if (cmd_i.start_stats) begin
        scan_active_q <= 1'b1;
        idx_q         <= '0;
      end else if (scan_active_q) begin
        idx_q <= idx_q + FILL_W'(1);
        if (idx_q == fill_q - FILL_W'(1)) begin
          scan_active_q <= 1'b0;
        end
      end
    end
  end

  // running minimum and maximum
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_stats) begin
      lo_q <= frws_pkg::RATE_MAX;
      hi_q <= '0;
    end else if (rd_valid_q) begin
      if (ram_rdata < lo_q) begin
        lo_q <= ram_rdata;
      end
      if (ram_rdata > hi_q) begin
        hi_q <= ram_rdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (stats_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cur_out_q <= rate_q;
      avg_out_q <= div_quo[RW-1:0];
      min_out_q <= lo_q;
      max_out_q <= hi_q;
    end
  end

  assign stats_valid_o  = out_valid_q;
  assign current_rate_o = cur_out_q;
  assign average_rate_o = avg_out_q;
  assign minimum_rate_o = min_out_q;
  assign maximum_rate_o = max_out_q;

  // status back to the controller
  assign status_o.div_busy  = div_busy;
  assign status_o.scan_busy = scan_active_q | rd_valid_q;
  assign status_o.out_free  = ~out_valid_q | stats_ready_i;

endmodule

[sv/frws_ctrl.sv]
// frws_ctrl: item sequencer for the frame rate window statistics block
// depends on frws_pkg
module frws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              frame_valid_i,
  output logic              frame_ready_o,
  input  frws_pkg::status_t status_i,
  output frws_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_PUSH,
    ST_START_STATS,
    ST_STATS,
    ST_FINISH
  } state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (frame_valid_i) begin
            state_q <= ST_DIV_RATE;
          end
        end
        ST_DIV_RATE: begin
          if (!status_i.div_busy) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          state_q <= ST_START_STATS;
        end
        ST_START_STATS: begin
          state_q <= ST_STATS;
        end
        ST_STATS: begin
          if (!status_i.div_busy && !status_i.scan_busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // commands decoded from state
  assign frame_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.load_item   = frame_ready_o & frame_valid_i;
  assign cmd_o.start_rate  = frame_ready_o & frame_valid_i;
  assign cmd_o.push        = (state_q == ST_PUSH);
  assign cmd_o.start_stats = (state_q == ST_START_STATS);
  assign cmd_o.load_out    = (state_q == ST_FINISH) & status_i.out_free;

endmodule

[sv/frame_rate_window_stats_top.sv]
// frame_rate_window_stats_top: top level with APB register port
// depends on frws_pkg, frws_ctrl, frws_dp (and through it frws_div, frws_ram)
//
// Each accepted item is one frame interval in timer ticks; the block returns
// one item holding the frame rate ticks_per_second*256/frame_ticks (unsigned
// Q16.8, saturating at all ones, also for a zero interval) together with the
// floor mean, minimum and maximum of up to the last WINDOW rates. A 40-step
// serial divider runs once for the rate and once for the average, and the
// second run overlaps the min/max scan, which reads the window store one
// entry per cycle. A new item is taken once the result is in the output
// register. ticks_per_second sits at byte address 0; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module frame_rate_window_stats_top #(
  parameter int WINDOW = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // frame interval items
  input  logic                              frame_valid_i,
  output logic                              frame_ready_o,
  input  logic [frws_pkg::TICKS_W-1:0]      frame_ticks_i,
  // statistics items
  output logic                              stats_valid_o,
  input  logic                              stats_ready_i,
  output logic [frws_pkg::RATE_W-1:0]       current_rate_o,
  output logic [frws_pkg::RATE_W-1:0]       average_rate_o,
  output logic [frws_pkg::RATE_W-1:0]       minimum_rate_o,
  output logic [frws_pkg::RATE_W-1:0]       maximum_rate_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [frws_pkg::APB_AW-1:0]       paddr,
  input  logic [frws_pkg::TPS_W-1:0]        pwdata,
  output logic [frws_pkg::TPS_W-1:0]        prdata,
  output logic                              pready
);

  frws_pkg::cmd_t             cmd;
  frws_pkg::status_t          status;
  logic                       cfg_we;
  logic [frws_pkg::TPS_W-1:0] tps;
  logic                       reg_hit;

  // register decode
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == frws_pkg::REG_TPS);
  assign cfg_we  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? tps : '0;

  frws_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid_i),
    .frame_ready_o (frame_ready_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  frws_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_ticks_i  (frame_ticks_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata),
    .tps_o          (tps),
    .stats_ready_i  (stats_ready_i),
    .stats_valid_o  (stats_valid_o),
    .current_rate_o (current_rate_o),
    .average_rate_o (average_rate_o),
    .minimum_rate_o (minimum_rate_o),
    .maximum_rate_o (maximum_rate_o)
  );

  // the current rate is always one of the window entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stats_valid_o |-> (minimum_rate_o <= current_rate_o) &&
                      (current_rate_o <= maximum_rate_o))
    else $error("current rate outside window min/max");

  // a floor mean lies between the window extremes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stats_valid_o |-> (minimum_rate_o <= average_rate_o) &&
                      (average_rate_o <= maximum_rate_o))
    else $error("average rate outside window min/max");

  // an accepted item keeps the block busy on the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_i && frame_ready_o) |=> !frame_ready_o)
    else $error("input taken again straight after an accepted item");

endmodule
